FILE: rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, character codes and helpers for the s-expression token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int OFFSET_BITS_DEFAULT = 20;
  localparam int LINE_BITS_DEFAULT   = 16;

  // Result queue depth; room for two results gates the input side.
  localparam int QUEUE_DEPTH = 4;

  typedef logic [19:0] off_field_t;
  typedef logic [15:0] line_field_t;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_LPAREN  = 4'd1,
    KIND_RPAREN  = 4'd2,
    KIND_NUMBER  = 4'd3,
    KIND_STRING  = 4'd4,
    KIND_NAME    = 4'd5,
    KIND_TRUE    = 4'd6,
    KIND_FALSE   = 4'd7,
    KIND_NIL     = 4'd8,
    KIND_BAD     = 4'd9,
    KIND_UNTERM  = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    off_field_t  start;
    off_field_t  length;
    line_field_t line;
    logic        last;
  } result_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  localparam logic [31:0] KW_TRUE  = 32'h7472_7565;
  localparam logic [39:0] KW_FALSE = 40'h66_616C_7365;
  localparam logic [23:0] KW_NIL   = 24'h6E_696C;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_name_byte(input logic [7:0] b);
    return (b >= CH_PRINT_LO) && (b <= CH_PRINT_HI) &&
           (b != CH_LPAREN) && (b != CH_RPAREN) && (b != CH_QUOTE);
  endfunction

endpackage

FILE: rtl/core/sts_scan.sv
// ----------------------------------------------------------------------------
// sts_scan
// Scanner state and per-byte classification; yields up to two results per item.
// ----------------------------------------------------------------------------
module sts_scan #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEFAULT,
  parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       text_byte,
  input  logic             end_marker,
  output logic [1:0]       res_count,
  output sts_pkg::result_t res_first,
  output sts_pkg::result_t res_second
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NAME = 3'd1,
    MODE_INT  = 3'd2,
    MODE_FRAC = 3'd3,
    MODE_STR  = 3'd4,
    MODE_DROP = 3'd5
  } mode_t;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [39:0]            keyword_window, keyword_window_next;
  logic [2:0]             name_len, name_len_next;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] tok_len;
  sts_pkg::kind_t         name_kind;
  logic                   first_v, scan_v, rescan;
  sts_pkg::kind_t         first_kind, scan_kind;
  logic [OFFSET_BITS-1:0] scan_len;
  sts_pkg::result_t       first_res, scan_res;

  assign pos_inc = (&byte_position) ? byte_position : byte_position + 1'b1;
  assign tok_len = byte_position - token_start;

  always_comb begin
    if (name_len == 3'd4 && keyword_window[31:0] == sts_pkg::KW_TRUE) begin
      name_kind = sts_pkg::KIND_TRUE;
    end else if (name_len == 3'd5 && keyword_window == sts_pkg::KW_FALSE) begin
      name_kind = sts_pkg::KIND_FALSE;
    end else if (name_len == 3'd3 && keyword_window[23:0] == sts_pkg::KW_NIL) begin
      name_kind = sts_pkg::KIND_NIL;
    end else begin
      name_kind = sts_pkg::KIND_NAME;
    end
  end

  always_comb begin
    mode_next           = mode;
    token_start_next    = token_start;
    byte_position_next  = byte_position;
    line_count_next     = line_count;
    keyword_window_next = keyword_window;
    name_len_next       = name_len;
    first_v    = 1'b0;
    first_kind = sts_pkg::KIND_NAME;
    scan_v     = 1'b0;
    scan_kind  = sts_pkg::KIND_END;
    scan_len   = OFFSET_BITS'(1);
    rescan     = 1'b0;

    if (end_marker) begin
      case (mode)
        MODE_NAME: begin
          first_v    = 1'b1;
          first_kind = name_kind;
        end
        MODE_INT, MODE_FRAC: begin
          first_v    = 1'b1;
          first_kind = sts_pkg::KIND_NUMBER;
        end
        MODE_STR: begin
          first_v    = 1'b1;
          first_kind = sts_pkg::KIND_UNTERM;
        end
        default: ;
      endcase
      scan_v              = 1'b1;
      scan_kind           = sts_pkg::KIND_END;
      scan_len            = '0;
      mode_next           = MODE_IDLE;
      token_start_next    = '0;
      byte_position_next  = '0;
      line_count_next     = LINE_BITS'(1);
      keyword_window_next = '0;
      name_len_next       = '0;
    end else begin
      case (mode)
        MODE_STR: begin
          if (text_byte == sts_pkg::CH_QUOTE) begin
            first_v    = 1'b1;
            first_kind = sts_pkg::KIND_STRING;
            mode_next  = MODE_IDLE;
          end
        end
        MODE_DROP: ;
        MODE_NAME: begin
          if (sts_pkg::is_name_byte(text_byte)) begin
            keyword_window_next = {keyword_window[31:0], text_byte};
            if (name_len != 3'd7) name_len_next = name_len + 3'd1;
          end else begin
            first_v    = 1'b1;
            first_kind = name_kind;
            rescan     = 1'b1;
          end
        end
        MODE_INT: begin
          if (text_byte == sts_pkg::CH_DOT) begin
            mode_next = MODE_FRAC;
          end else if (!sts_pkg::is_digit(text_byte)) begin
            first_v    = 1'b1;
            first_kind = sts_pkg::KIND_NUMBER;
            rescan     = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!sts_pkg::is_digit(text_byte)) begin
            first_v    = 1'b1;
            first_kind = sts_pkg::KIND_NUMBER;
            rescan     = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      // Scan the byte as the possible start of a new token.
      if (rescan) begin
        mode_next = MODE_IDLE;
        if (text_byte == sts_pkg::CH_SPACE || text_byte == sts_pkg::CH_TAB ||
            text_byte == sts_pkg::CH_CR) begin
          mode_next = MODE_IDLE;
        end else if (text_byte == sts_pkg::CH_LF) begin
          if (!(&line_count)) line_count_next = line_count + 1'b1;
        end else if (sts_pkg::is_digit(text_byte)) begin
          token_start_next = byte_position;
          mode_next        = MODE_INT;
        end else if (text_byte == sts_pkg::CH_QUOTE) begin
          token_start_next = pos_inc;
          mode_next        = MODE_STR;
        end else if (text_byte == sts_pkg::CH_LPAREN) begin
          scan_v    = 1'b1;
          scan_kind = sts_pkg::KIND_LPAREN;
        end else if (text_byte == sts_pkg::CH_RPAREN) begin
          scan_v    = 1'b1;
          scan_kind = sts_pkg::KIND_RPAREN;
        end else if (sts_pkg::is_name_byte(text_byte)) begin
          token_start_next    = byte_position;
          keyword_window_next = {32'd0, text_byte};
          name_len_next       = 3'd1;
          mode_next           = MODE_NAME;
        end else begin
          scan_v    = 1'b1;
          scan_kind = sts_pkg::KIND_BAD;
          mode_next = MODE_DROP;
        end
      end
      byte_position_next = pos_inc;
    end
  end

  always_comb begin
    first_res.kind    = first_kind;
    first_res.start   = sts_pkg::off_field_t'(token_start);
    first_res.length  = sts_pkg::off_field_t'(tok_len);
    first_res.line    = sts_pkg::line_field_t'(line_count);
    first_res.last    = !scan_v;
    scan_res.kind     = scan_kind;
    scan_res.start    = sts_pkg::off_field_t'(byte_position);
    scan_res.length   = sts_pkg::off_field_t'(scan_len);
    scan_res.line     = sts_pkg::line_field_t'(line_count);
    scan_res.last     = 1'b1;
  end

  assign res_count  = take ? ({1'b0, first_v} + {1'b0, scan_v}) : 2'd0;
  assign res_first  = first_v ? first_res : scan_res;
  assign res_second = scan_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      token_start    <= '0;
      byte_position  <= '0;
      line_count     <= LINE_BITS'(1);
      keyword_window <= '0;
      name_len       <= '0;
    end else if (take) begin
      mode           <= mode_next;
      token_start    <= token_start_next;
      byte_position  <= byte_position_next;
      line_count     <= line_count_next;
      keyword_window <= keyword_window_next;
      name_len       <= name_len_next;
    end
  end

endmodule

FILE: rtl/core/sts_result_queue.sv
// ----------------------------------------------------------------------------
// sts_result_queue
// Small result queue: writes up to two results a cycle, drains one a cycle.
// ----------------------------------------------------------------------------
module sts_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  sts_pkg::result_t push_first,
  input  sts_pkg::result_t push_second,
  output logic             has_room,
  output logic             head_valid,
  input  logic             head_ready,
  output sts_pkg::result_t head
);

  localparam int DEPTH = sts_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sts_pkg::result_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_plus1;

  assign pop          = head_valid && head_ready;
  assign head_valid   = (count != '0);
  assign head         = slots[rd_ptr];
  assign has_room     = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr_plus1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slots[wr_ptr] <= push_first;
    if (push_count == 2'd2) slots[wr_ptr_plus1] <= push_second;
  end

endmodule

FILE: rtl/core/sexpr_token_scanner.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// S-expression tokenizer: one text byte per request, tokens out as results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per text byte, or an
//   end marker. Output channel (out_valid/out_ready) carries token results:
//   kind, start offset, length, line and a flag on the last result of a
//   request. A request yields zero, one or two results.
//   The results of a request are registered in the result queue and are
//   visible on the output in the cycle after it is taken (when the queue
//   ahead of them is empty). Throughput: one request per cycle while each
//   request yields at most one result and the receiver takes every result;
//   two results of one request leave one at a time by the single output port.
//   in_ready depends only on the result queue fill (room for two results),
//   never on out_ready in the same cycle.
//   Reset clears the scanner to idle, offset zero, line one, and empties the
//   result queue. The end marker also returns the scanner to that state.
//   When the receiver stalls, results stay in the four-entry queue; once it
//   holds more than two, in_ready drops until the receiver drains it.
// ----------------------------------------------------------------------------
module sexpr_token_scanner #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEFAULT,
  parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_marker,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [19:0] start_offset,
  output logic [19:0] token_length,
  output logic [15:0] line_number,
  output logic        last_of_run
);

  logic             take;
  logic [1:0]       res_count;
  sts_pkg::result_t res_first, res_second;
  sts_pkg::result_t head;
  logic             has_room;

  // Take a request only when the queue can absorb both possible results.
  assign in_ready = has_room;
  assign take     = in_valid && in_ready;

  sts_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .text_byte  (text_byte),
    .end_marker (end_marker),
    .res_count  (res_count),
    .res_first  (res_first),
    .res_second (res_second)
  );

  sts_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (res_count),
    .push_first  (res_first),
    .push_second (res_second),
    .has_room    (has_room),
    .head_valid  (out_valid),
    .head_ready  (out_ready),
    .head        (head)
  );

  // Unpack the head of the queue onto the result ports.
  assign token_kind   = head.kind;
  assign start_offset = head.start;
  assign token_length = head.length;
  assign line_number  = head.line;
  assign last_of_run  = head.last;

endmodule

FILE: tb/tb_sexpr_token_scanner.sv
// ----------------------------------------------------------------------------
// tb_sexpr_token_scanner
// Self-checking bench for the s-expression token scanner: short directed
// texts and random s-expression texts go through a queue-fed driver. Each
// accepted request is scanned by a local model of the scanner. A monitor
// compares every result against the oldest predicted token. Both sides idle
// in random bursts, and the receiver once holds off long enough to
// back-pressure the input.
// ----------------------------------------------------------------------------
module tb_sexpr_token_scanner;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Pending requests left when idling stops for the tail of the run.
  localparam int CALM_TAIL = 150;
  // Receiver hold-off length and the backlog at which it starts.
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT = 800;
  localparam int RANDOM_ITEMS = 1420;

  // Scanner modes of the local model.
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NAME, SCAN_INT, SCAN_FRAC, SCAN_STR, SCAN_DROP
  } scan_mode_t;

  // One request as the driver sends it.
  typedef struct packed {
    logic [7:0] data;
    logic       endm;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        end_marker = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  token_kind;
  logic [19:0] start_offset;
  logic [19:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  text_item_t       text_q[$];   // requests not yet offered
  sts_pkg::result_t token_q[$];  // predicted tokens, oldest first
  sts_pkg::result_t step_q[$];   // tokens caused by the request being scanned

  int unsigned errors = 0;

  // Local copy of the scanner state.
  scan_mode_t  mode = SCAN_IDLE;
  logic [19:0] tok_start = '0;
  logic [19:0] pos = '0;
  logic [15:0] line = 16'd1;
  logic [39:0] kw_win = '0;
  logic [2:0]  name_len = '0;

  sexpr_token_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_marker   (end_marker),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------

  function automatic bit is_num_char(input logic [7:0] b);
    return b >= sts_pkg::CH_ZERO && b <= sts_pkg::CH_NINE;
  endfunction

  // Printable, but not a paren or a quote.
  function automatic bit is_name_char(input logic [7:0] b);
    return b >= sts_pkg::CH_PRINT_LO && b <= sts_pkg::CH_PRINT_HI &&
           b != sts_pkg::CH_LPAREN && b != sts_pkg::CH_RPAREN &&
           b != sts_pkg::CH_QUOTE;
  endfunction

  // Keywords need both the exact length and the exact tail of the window.
  function automatic sts_pkg::kind_t name_kind_of();
    if (name_len == 3'd4 && kw_win[31:0] == sts_pkg::KW_TRUE) return sts_pkg::KIND_TRUE;
    if (name_len == 3'd5 && kw_win == sts_pkg::KW_FALSE) return sts_pkg::KIND_FALSE;
    if (name_len == 3'd3 && kw_win[23:0] == sts_pkg::KW_NIL) return sts_pkg::KIND_NIL;
    return sts_pkg::KIND_NAME;
  endfunction

  task automatic emit(input sts_pkg::kind_t k, input logic [19:0] s,
                      input logic [19:0] l);
    sts_pkg::result_t r;
    r.kind = k;
    r.start = s;
    r.length = l;
    r.line = line;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  // Scan one accepted request and queue the tokens it yields.
  task automatic scan_request(input logic [7:0] b, input logic endm);
    sts_pkg::result_t r;
    bit               rescan;
    step_q.delete();
    if (endm) begin
      // Flush whatever token is open, then END; the text starts over.
      case (mode)
        SCAN_NAME: emit(name_kind_of(), tok_start, pos - tok_start);
        SCAN_INT, SCAN_FRAC: emit(sts_pkg::KIND_NUMBER, tok_start, pos - tok_start);
        SCAN_STR: emit(sts_pkg::KIND_UNTERM, tok_start, pos - tok_start);
        default: ;
      endcase
      emit(sts_pkg::KIND_END, pos, '0);
      mode = SCAN_IDLE;
      tok_start = '0;
      pos = '0;
      line = 16'd1;
      kw_win = '0;
      name_len = '0;
    end else begin
      rescan = 1'b1;
      case (mode)
        SCAN_STR: begin
          // Anything but a quote is content, LF included.
          rescan = 1'b0;
          if (b == sts_pkg::CH_QUOTE) begin
            emit(sts_pkg::KIND_STRING, tok_start, pos - tok_start);
            mode = SCAN_IDLE;
          end
        end
        SCAN_DROP: rescan = 1'b0;
        SCAN_NAME: begin
          if (is_name_char(b)) begin
            kw_win = {kw_win[31:0], b};
            if (name_len < 3'd7) name_len = name_len + 3'd1;
            rescan = 1'b0;
          end else begin
            emit(name_kind_of(), tok_start, pos - tok_start);
            mode = SCAN_IDLE;
          end
        end
        SCAN_INT: begin
          if (is_num_char(b)) begin
            rescan = 1'b0;
          end else if (b == sts_pkg::CH_DOT) begin
            mode = SCAN_FRAC;
            rescan = 1'b0;
          end else begin
            emit(sts_pkg::KIND_NUMBER, tok_start, pos - tok_start);
            mode = SCAN_IDLE;
          end
        end
        SCAN_FRAC: begin
          if (is_num_char(b)) begin
            rescan = 1'b0;
          end else begin
            emit(sts_pkg::KIND_NUMBER, tok_start, pos - tok_start);
            mode = SCAN_IDLE;
          end
        end
        default: ;
      endcase
      // A byte that closed a token is looked at again as a token start.
      if (rescan) begin
        if (b == sts_pkg::CH_SPACE || b == sts_pkg::CH_TAB || b == sts_pkg::CH_CR) begin
        end else if (b == sts_pkg::CH_LF) begin
          if (line != 16'hFFFF) line = line + 16'd1;
        end else if (is_num_char(b)) begin
          tok_start = pos;
          mode = SCAN_INT;
        end else if (b == sts_pkg::CH_QUOTE) begin
          tok_start = (pos != 20'hFFFFF) ? pos + 20'd1 : pos;
          mode = SCAN_STR;
        end else if (b == sts_pkg::CH_LPAREN) begin
          emit(sts_pkg::KIND_LPAREN, pos, 20'd1);
        end else if (b == sts_pkg::CH_RPAREN) begin
          emit(sts_pkg::KIND_RPAREN, pos, 20'd1);
        end else if (is_name_char(b)) begin
          tok_start = pos;
          kw_win = {32'h0, b};
          name_len = 3'd1;
          mode = SCAN_NAME;
        end else begin
          emit(sts_pkg::KIND_BAD, pos, 20'd1);
          mode = SCAN_DROP;
        end
      end
      if (pos != 20'hFFFFF) pos = pos + 20'd1;
    end
    // Flag the final token of this request, then hand them all over.
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b);
    text_item_t it;
    it.data = b;
    it.endm = 1'b0;
    text_q.push_back(it);
  endtask

  // The byte lane carries junk with the end marker; the scanner ignores it.
  task automatic add_end();
    text_item_t it;
    it.data = 8'($urandom_range(0, 255));
    it.endm = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_name_char();
    logic [7:0] b;
    do b = 8'($urandom_range(sts_pkg::CH_PRINT_LO, sts_pkg::CH_PRINT_HI));
    while (!is_name_char(b));
    return b;
  endfunction

  // Build one random text ending in the end marker; return its request count.
  task automatic add_random_text(output int n_items);
    int         n_tok;
    int         sel;
    int         len;
    logic [7:0] b;
    bit         dropped;
    string      kw;
    n_items = 0;
    dropped = 1'b0;
    n_tok = $urandom_range(1, 12);
    for (int t = 0; t < n_tok && !dropped; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        add_byte(sts_pkg::CH_LPAREN);
        n_items++;
      end else if (sel < 24) begin
        add_byte(sts_pkg::CH_RPAREN);
        n_items++;
      end else if (sel < 40) begin
        // Digits, maybe a dot, maybe a fraction; a bare "12." is legal.
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          add_byte(8'($urandom_range(sts_pkg::CH_ZERO, sts_pkg::CH_NINE)));
        n_items += len;
        if ($urandom_range(0, 1)) begin
          add_byte(sts_pkg::CH_DOT);
          len = $urandom_range(0, 3);
          for (int i = 0; i < len; i++)
            add_byte(8'($urandom_range(sts_pkg::CH_ZERO, sts_pkg::CH_NINE)));
          n_items += len + 1;
        end
      end else if (sel < 52) begin
        // String with arbitrary content, LF and high bytes included.
        add_byte(sts_pkg::CH_QUOTE);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom_range(0, 255));
          while (b == sts_pkg::CH_QUOTE);
          add_byte(b);
        end
        add_byte(sts_pkg::CH_QUOTE);
        n_items += len + 2;
      end else if (sel < 80) begin
        add_byte(pick_name_char());
        len = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) add_byte(pick_name_char());
        n_items += len + 1;
      end else if (sel < 95) begin
        // Keywords and near misses that share a tail or a prefix.
        case ($urandom_range(0, 9))
          0, 1: kw = "true";
          2, 3: kw = "false";
          4, 5: kw = "nil";
          6: kw = "xtrue";
          7: kw = "falsey";
          8: kw = "ni";
          default: kw = "ffalse";
        endcase
        add_text(kw);
        n_items += kw.len();
      end else begin
        // Unexpected byte, then a little noise that gets dropped.
        if ($urandom_range(0, 1)) begin
          do b = 8'($urandom_range(0, 31));
          while (b == sts_pkg::CH_TAB || b == sts_pkg::CH_LF || b == sts_pkg::CH_CR);
        end else begin
          b = 8'($urandom_range(8'h7F, 8'hFF));
        end
        add_byte(b);
        n_items++;
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
        n_items += len;
        dropped = 1'b1;
      end
      // Separator: usually white space, sometimes tokens butt together.
      if (!dropped && $urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0: b = sts_pkg::CH_TAB;
          1: b = sts_pkg::CH_CR;
          2, 3: b = sts_pkg::CH_LF;
          default: b = sts_pkg::CH_SPACE;
        endcase
        add_byte(b);
        n_items++;
      end
    end
    // Sometimes leave a string open at the end marker.
    if (!dropped && $urandom_range(0, 9) == 0) begin
      add_byte(sts_pkg::CH_QUOTE);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) add_byte(pick_name_char());
      n_items += len + 1;
    end
    add_end();
    n_items++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued requests, idling in random bursts
  // --------------------------------------------------------------------------

  int src_gap = 0;

  always @(posedge clk) begin : driver
    text_item_t nxt;
    bit         fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) scan_request(text_byte, end_marker);
      // Hold the current request until it is taken.
      if (fire || !in_valid) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          nxt = text_q.pop_front();
          text_byte <= nxt.data;
          end_marker <= nxt.endm;
          in_valid <= 1'b1;
          if (text_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off to fill the result queue
  // --------------------------------------------------------------------------

  int sink_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (!hold_done && text_q.size() < HOLD_AT) begin
      // The sender keeps offering meanwhile, so in_ready must drop.
      hold_done = 1'b1;
      hold_cnt = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (text_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
        sink_gap = $urandom_range(1, 17);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result with the oldest predicted token
  // --------------------------------------------------------------------------

  task automatic report(input string what, input logic [39:0] want, input logic [39:0] got);
    errors++;
    $display("ERROR %s: expected %0h got %0h", what, want, got);
  endtask

  always @(posedge clk) begin : monitor
    sts_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        report("result with no token predicted, kind", '0, token_kind);
      end else begin
        want = token_q.pop_front();
        if (token_kind !== want.kind) report("token_kind", want.kind, token_kind);
        if (start_offset !== want.start) report("start_offset", want.start, start_offset);
        if (token_length !== want.length) report("token_length", want.length, token_length);
        if (line_number !== want.line) report("line_number", want.line, line_number);
        if (last_of_run !== want.last) report("last_of_run", want.last, last_of_run);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no handshake happens for too long
  // --------------------------------------------------------------------------

  int stall_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sexpr_token_scanner: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin : sequencer
    int n_random;
    int n_text;
    // Directed: parens, nil, a number ending in a bare dot cut by ')'.
    add_text("(nil");
    add_byte(sts_pkg::CH_TAB);
    add_text("7.)");
    add_byte(sts_pkg::CH_CR);
    add_end();
    // false cut by LF, then a string left open with a NUL in it.
    add_text("false");
    add_byte(sts_pkg::CH_LF);
    add_byte(sts_pkg::CH_QUOTE);
    add_byte(8'h00);
    add_end();
    // true cut by DEL gives two tokens; the rest is dropped.
    add_text("true");
    add_byte(8'h7F);
    add_byte(8'hFF);
    add_byte(sts_pkg::CH_LPAREN);
    add_end();
    // Empty text.
    add_end();

    // Random s-expression texts.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      add_random_text(n_text);
      n_random += n_text;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything offered, accepted and matched.
    while (text_q.size() > 0 || in_valid || token_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && token_q.size() == 0) begin
      $display("sexpr_token_scanner: match");
    end else begin
      $display("sexpr_token_scanner: mismatch");
    end
    $finish;
  end

endmodule
